[hdl/wlan_rx_header_parse_fcs_check_assert.svh]
// ---------------------------------------------------------------------------
// WLAN receive parser assertion macros
// Shorthand for clocked implication checks with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef WLAN_RX_HEADER_PARSE_FCS_CHECK_ASSERT_SVH
`define WLAN_RX_HEADER_PARSE_FCS_CHECK_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define WLRX_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define WLRX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wlrx_pkg.sv]
// ---------------------------------------------------------------------------
// WLAN receive parser package
// Types, header offsets, frame codes and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
package wlrx_pkg;

    localparam int CNT_W           = 13;
    localparam int MAX_FRAME_BYTES = 8191;

    localparam logic [CNT_W-1:0] MAX_COUNT     = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] FCS_BYTES     = CNT_W'(4);
    localparam logic [CNT_W-1:0] SEQ_OFS       = CNT_W'(22);
    localparam logic [CNT_W-1:0] QOS_OFS       = CNT_W'(24);
    localparam logic [CNT_W-1:0] QOS_OFS_4ADDR = CNT_W'(30);

    localparam logic [1:0] TYPE_CTRL = 2'd1;
    localparam logic [1:0] TYPE_DATA = 2'd2;
    localparam logic [3:0] SUBTYPE_QOS_DATA = 4'd8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] frame_byte;
    } in_word_t;

    typedef struct packed {
        logic             fcs_ok;
        logic [1:0]       frame_type;
        logic [3:0]       frame_subtype;
        logic [7:0]       flag_bits;
        logic [15:0]      duration_id;
        logic [11:0]      seq_num;
        logic [3:0]       frag_num;
        logic             qos_present;
        logic [3:0]       qos_tid;
        logic [1:0]       qos_ack_policy;
        logic [CNT_W-1:0] frame_length;
    } result_t;

    // Reflected CRC-32, one byte per call (eight bit steps, pure XOR logic).
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/wlrx_in_stage.sv]
// ---------------------------------------------------------------------------
// WLAN receive parser input register
// Holds one received word; refills in the cycle the core takes the old one.
// ---------------------------------------------------------------------------
module wlrx_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  wlrx_pkg::in_word_t s_word,
    output logic               word_valid,
    output wlrx_pkg::in_word_t word,
    input  logic               word_take
);
    import wlrx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign s_tready   = !valid_reg || word_take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !word_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

[hdl/wlrx_core.sv]
// ---------------------------------------------------------------------------
// WLAN receive parser frame core
// Per-byte CRC update, FCS delay line, header capture and frame summary.
// ---------------------------------------------------------------------------
module wlrx_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               word_valid,
    input  wlrx_pkg::in_word_t word,
    output logic               word_take,
    input  logic               res_ready,
    output logic               res_valid,
    output wlrx_pkg::result_t  res
);
    import wlrx_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      tail_reg, tail_next;
    logic [15:0]      ctrl_reg, ctrl_next;
    logic [15:0]      dur_reg, dur_next;
    logic [15:0]      seqctl_reg, seqctl_next;
    logic [15:0]      qosctl_reg, qosctl_next;

    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count_upd;
    logic [CNT_W-1:0] qos_ofs;
    logic [31:0]      crc_upd;
    logic [31:0]      tail_upd;
    logic [15:0]      ctrl_upd, dur_upd, seqctl_upd, qosctl_upd;
    logic [7:0]       b;
    logic             fcs_ok;
    logic             is_qos;

    // Non-last bytes never produce a result, so only the last byte waits.
    assign word_take = word_valid && (!word.last_byte || res_ready);
    assign res_valid = word_take && word.last_byte;
    assign b         = word.frame_byte;
    assign idx       = byte_count_reg;

    always_comb begin
        crc_upd  = (idx >= FCS_BYTES) ? crc_byte(crc_reg, tail_reg[7:0]) : crc_reg;
        tail_upd = {b, tail_reg[31:8]};

        ctrl_upd   = ctrl_reg;
        dur_upd    = dur_reg;
        seqctl_upd = seqctl_reg;
        qosctl_upd = qosctl_reg;
        if (idx == CNT_W'(0)) ctrl_upd[7:0]  = b;
        if (idx == CNT_W'(1)) ctrl_upd[15:8] = b;
        if (idx == CNT_W'(2)) dur_upd[7:0]   = b;
        if (idx == CNT_W'(3)) dur_upd[15:8]  = b;
        if (idx == SEQ_OFS)            seqctl_upd[7:0]  = b;
        if (idx == SEQ_OFS + CNT_W'(1)) seqctl_upd[15:8] = b;

        // Four-address frames push the QoS field out by one address.
        qos_ofs = (ctrl_upd[9:8] == 2'b11) ? QOS_OFS_4ADDR : QOS_OFS;
        if (idx == qos_ofs)             qosctl_upd[7:0]  = b;
        if (idx == qos_ofs + CNT_W'(1)) qosctl_upd[15:8] = b;

        count_upd = (byte_count_reg != MAX_COUNT) ? byte_count_reg + CNT_W'(1)
                                                  : byte_count_reg;

        fcs_ok = (count_upd >= FCS_BYTES) && ((crc_upd ^ CRC_INIT) == tail_upd);
        is_qos = (ctrl_upd[3:2] == TYPE_DATA) && (ctrl_upd[7:4] == SUBTYPE_QOS_DATA)
                 && (count_upd >= qos_ofs + CNT_W'(2));

        res                = '0;
        res.fcs_ok         = fcs_ok;
        res.frame_length   = count_upd;
        if (fcs_ok) begin
            res.frame_type    = ctrl_upd[3:2];
            res.frame_subtype = ctrl_upd[7:4];
            res.flag_bits     = ctrl_upd[15:8];
            res.duration_id   = dur_upd;
            if (ctrl_upd[3:2] != TYPE_CTRL) begin
                res.seq_num  = seqctl_upd[15:4];
                res.frag_num = seqctl_upd[3:0];
            end
            if (is_qos) begin
                res.qos_present    = 1'b1;
                res.qos_tid        = qosctl_upd[3:0];
                res.qos_ack_policy = qosctl_upd[6:5];
            end
        end

        // Hold when idle, advance on a byte, restart after the last byte.
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        tail_next       = tail_reg;
        ctrl_next       = ctrl_reg;
        dur_next        = dur_reg;
        seqctl_next     = seqctl_reg;
        qosctl_next     = qosctl_reg;
        if (word_take) begin
            if (word.last_byte) begin
                byte_count_next = '0;
                crc_next        = CRC_INIT;
                tail_next       = '0;
                ctrl_next       = '0;
                dur_next        = '0;
                seqctl_next     = '0;
                qosctl_next     = '0;
            end else begin
                byte_count_next = count_upd;
                crc_next        = crc_upd;
                tail_next       = tail_upd;
                ctrl_next       = ctrl_upd;
                dur_next        = dur_upd;
                seqctl_next     = seqctl_upd;
                qosctl_next     = qosctl_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            tail_reg       <= '0;
            ctrl_reg       <= '0;
            dur_reg        <= '0;
            seqctl_reg     <= '0;
            qosctl_reg     <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            tail_reg       <= tail_next;
            ctrl_reg       <= ctrl_next;
            dur_reg        <= dur_next;
            seqctl_reg     <= seqctl_next;
            qosctl_reg     <= qosctl_next;
        end
    end

endmodule

[hdl/wlrx_out_stage.sv]
// ---------------------------------------------------------------------------
// WLAN receive parser output register
// Holds one frame summary until the downstream side takes it.
// ---------------------------------------------------------------------------
module wlrx_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  wlrx_pkg::result_t res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wlrx_pkg::result_t m_res
);
    import wlrx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

[hdl/wlan_rx_header_parse_fcs_check.sv]
// ---------------------------------------------------------------------------
// WLAN receive header parser with FCS check
// Parses one 802.11 MPDU per frame, one byte per word, and reports a summary.
// ---------------------------------------------------------------------------
// Feed the MPDU one byte per word on the s_ side with s_tlast on the final
// FCS byte; one summary word leaves on the m_ side per frame. The block takes
// one byte every cycle: the byte-wide CRC-32 update plus header capture works
// on each byte while it sits in the input register, and the summary of a
// frame is registered in the output register, which drives m_tvalid.
// The per-cycle path is the eight-step CRC XOR network followed
// by the 32-bit FCS compare. s_tready drops only while a finished summary
// waits in the output register and the next last byte is already queued.
// A failed FCS (or a frame under four bytes) zeroes every summary field except
// fcs_ok and frame_length; frame_length saturates at 8191.
module wlan_rx_header_parse_fcs_check (
    input  logic        aclk,
    input  logic        aresetn,
    // Receive byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    // Frame summary
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] frame_type, [5:2] frame_subtype, [13:6] flag_bits,
    // [29:14] duration_id, [41:30] seq_num, [45:42] frag_num,
    // [46] qos_present, [50:47] qos_tid, [52:51] qos_ack_policy,
    // [65:53] frame_length, [71:66] zero
    output logic [71:0] m_tdata,
    output logic        m_tuser    // [0] fcs_ok
);
    import wlrx_pkg::*;

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     word_take;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  m_res;

    assign s_word.frame_byte = s_tdata;
    assign s_word.last_byte  = s_tlast;

    // Register the incoming byte.
    wlrx_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take)
    );

    // CRC, FCS delay line, header capture and summary.
    wlrx_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Hold the summary for the downstream side.
    wlrx_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // Pack the summary, first field in the lowest bits.
    assign m_tuser = m_res.fcs_ok;
    assign m_tdata = {6'h0,
                      m_res.frame_length,
                      m_res.qos_ack_policy,
                      m_res.qos_tid,
                      m_res.qos_present,
                      m_res.frag_num,
                      m_res.seq_num,
                      m_res.duration_id,
                      m_res.flag_bits,
                      m_res.frame_subtype,
                      m_res.frame_type};

`include "wlan_rx_header_parse_fcs_check_assert.svh"

    // A failed check must blank every header field.
    `WLRX_ASSERT_NOW(a_bad_fcs_blank, aclk, aresetn,
                     m_tvalid && !m_tuser, m_tdata[52:0] == 53'h0,
                     "header fields set on failed FCS")

    // A good FCS needs at least the four FCS bytes.
    `WLRX_ASSERT_NOW(a_ok_min_len, aclk, aresetn,
                     m_tvalid && m_tuser, m_res.frame_length >= FCS_BYTES,
                     "FCS reported good on a frame under four bytes")

    // QoS fields only come from QoS data frames.
    `WLRX_ASSERT_NOW(a_qos_kind, aclk, aresetn,
                     m_tvalid && m_res.qos_present,
                     (m_res.frame_type == TYPE_DATA) &&
                     (m_res.frame_subtype == SUBTYPE_QOS_DATA),
                     "QoS fields on a non-QoS-data frame")

    // A summary taken from the core appears on the output next cycle.
    `WLRX_ASSERT_NEXT(a_res_lands, aclk, aresetn,
                      res_valid && res_ready, m_tvalid,
                      "summary lost between core and output register")

endmodule
